FILE: design/awbg_pkg.sv
// ----------------------------------------------------------------------------
// awbg_pkg
// Shared types and constants for the white-balance gain calibration block.
// ----------------------------------------------------------------------------
package awbg_pkg;

  localparam int unsigned RatioW  = 10;  // raw and typical ratio width
  localparam int unsigned SratioW = 11;  // light-scaled ratio width
  localparam int unsigned GainW   = 16;  // output gain width
  localparam int unsigned StatW   = 2;
  localparam int unsigned CfgIdxW = 2;

  // First divider level: 1024*ratio / typical.
  localparam int unsigned Div1N = SratioW + 10;
  // Second divider level: G * typical / ratio.
  localparam int unsigned Div2N = Div1N + RatioW;

  localparam logic [RatioW-1:0]  TypRedRst  = 10'h127;
  localparam logic [RatioW-1:0]  TypBlueRst = 10'h14E;
  localparam logic [SratioW-1:0] LightBias  = 11'd512;
  localparam logic [Div1N-1:0]   UnityGain  = 21'h400;
  localparam logic [GainW-1:0]   GainMax    = 16'hFFFF;
  localparam logic [GainW-1:0]   GainUnity  = 16'h0400;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TYP_RED  = 2'd0,
    REG_TYP_BLUE = 2'd1
  } cfg_reg_e;

  typedef enum logic [StatW-1:0] {
    STAT_OK   = 2'd0,
    STAT_SAT  = 2'd1,
    STAT_ZERO = 2'd2
  } stat_e;

  // Which channel sits at unity gain.
  typedef enum logic [1:0] {
    MODE_G_UNITY = 2'd0,
    MODE_R_UNITY = 2'd1,
    MODE_B_UNITY = 2'd2
  } mode_e;

  typedef struct packed {
    logic   zero;
    mode_e  mode;
  } sel_ctl_t;

endpackage

FILE: design/awbg_div_cell.sv
// ----------------------------------------------------------------------------
// awbg_div_cell
// One restoring division step for two lanes, with a pass-along sideband.
// ----------------------------------------------------------------------------
module awbg_div_cell #(
  parameter int unsigned N  = 21,
  parameter int unsigned M  = 10,
  parameter int unsigned SW = 22
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  logic [M-1:0]  rem_a_i,
  input  logic [N-1:0]  dq_a_i,
  input  logic [M-1:0]  dvs_a_i,
  input  logic [M-1:0]  rem_b_i,
  input  logic [N-1:0]  dq_b_i,
  input  logic [M-1:0]  dvs_b_i,
  input  logic [SW-1:0] side_i,
  output logic          vld_o,
  output logic [M-1:0]  rem_a_o,
  output logic [N-1:0]  dq_a_o,
  output logic [M-1:0]  dvs_a_o,
  output logic [M-1:0]  rem_b_o,
  output logic [N-1:0]  dq_b_o,
  output logic [M-1:0]  dvs_b_o,
  output logic [SW-1:0] side_o
);

  logic [M:0]   trial_a, trial_b, diff_a, diff_b;
  logic         ge_a, ge_b;
  logic         vld_q;
  logic [M-1:0] rem_a_q, rem_b_q, dvs_a_q, dvs_b_q;
  logic [N-1:0] dq_a_q, dq_b_q;
  logic [SW-1:0] side_q;

  // The dividend shifts out at the top while quotient bits enter at the bottom.
  always_comb begin
    trial_a = {rem_a_i, dq_a_i[N-1]};
    trial_b = {rem_b_i, dq_b_i[N-1]};
    ge_a    = trial_a >= {1'b0, dvs_a_i};
    ge_b    = trial_b >= {1'b0, dvs_b_i};
    diff_a  = ge_a ? (trial_a - {1'b0, dvs_a_i}) : trial_a;
    diff_b  = ge_b ? (trial_b - {1'b0, dvs_b_i}) : trial_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_a_q <= diff_a[M-1:0];
      rem_b_q <= diff_b[M-1:0];
      dq_a_q  <= {dq_a_i[N-2:0], ge_a};
      dq_b_q  <= {dq_b_i[N-2:0], ge_b};
      dvs_a_q <= dvs_a_i;
      dvs_b_q <= dvs_b_i;
      side_q  <= side_i;
    end
  end

  assign vld_o   = vld_q;
  assign rem_a_o = rem_a_q;
  assign rem_b_o = rem_b_q;
  assign dq_a_o  = dq_a_q;
  assign dq_b_o  = dq_b_q;
  assign dvs_a_o = dvs_a_q;
  assign dvs_b_o = dvs_b_q;
  assign side_o  = side_q;

endmodule

FILE: design/awbg_div_chain.sv
// ----------------------------------------------------------------------------
// awbg_div_chain
// Row of division cells giving two N-bit quotients, one bit per cell.
// ----------------------------------------------------------------------------
module awbg_div_chain #(
  parameter int unsigned N  = 21,
  parameter int unsigned M  = 10,
  parameter int unsigned SW = 22
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  logic [N-1:0]  dnd_a_i,
  input  logic [M-1:0]  dvs_a_i,
  input  logic [N-1:0]  dnd_b_i,
  input  logic [M-1:0]  dvs_b_i,
  input  logic [SW-1:0] side_i,
  output logic          vld_o,
  output logic [N-1:0]  quo_a_o,
  output logic [N-1:0]  quo_b_o,
  output logic [SW-1:0] side_o
);

  logic [N:0]                vld;
  logic [N:0][M-1:0]         rem_a, rem_b, dvs_a, dvs_b;
  logic [N:0][N-1:0]         dq_a, dq_b;
  logic [N:0][SW-1:0]        side;

  assign vld[0]   = vld_i;
  assign rem_a[0] = '0;
  assign rem_b[0] = '0;
  assign dq_a[0]  = dnd_a_i;
  assign dq_b[0]  = dnd_b_i;
  assign dvs_a[0] = dvs_a_i;
  assign dvs_b[0] = dvs_b_i;
  assign side[0]  = side_i;

  for (genvar i = 0; i < N; i++) begin : g_cell
    awbg_div_cell #(.N(N), .M(M), .SW(SW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en_i),
      .vld_i   (vld[i]),
      .rem_a_i (rem_a[i]),
      .dq_a_i  (dq_a[i]),
      .dvs_a_i (dvs_a[i]),
      .rem_b_i (rem_b[i]),
      .dq_b_i  (dq_b[i]),
      .dvs_b_i (dvs_b[i]),
      .side_i  (side[i]),
      .vld_o   (vld[i+1]),
      .rem_a_o (rem_a[i+1]),
      .dq_a_o  (dq_a[i+1]),
      .dvs_a_o (dvs_a[i+1]),
      .rem_b_o (rem_b[i+1]),
      .dq_b_o  (dq_b[i+1]),
      .dvs_b_o (dvs_b[i+1]),
      .side_o  (side[i+1])
    );
  end

  assign vld_o   = vld[N];
  assign quo_a_o = dq_a[N];
  assign quo_b_o = dq_b[N];
  assign side_o  = side[N];

endmodule

FILE: design/awb_gain_from_otp_ratios.sv
// ----------------------------------------------------------------------------
// awb_gain_from_otp_ratios
// White-balance gains from one module's calibrated red and blue ratios.
// ----------------------------------------------------------------------------
// Input words carry the red/blue ratios and their light factors on
// in_valid_i / in_stall_o; result words carry three gains and a status on
// out_valid_o / out_stall_i. A word moves when valid is high and stall low.
// The user writes the typical ratios through cfg_we_i / cfg_idx_i / cfg_data_i
// only while the block is idle; the block itself does not enforce this.
// Throughput is one word per cycle while in_stall_o is low. From input accept
// to output valid a word passes the light scaling register, 21 cells of the
// first divider row, a case select and a multiply stage, 31 cells of the
// second divider row and the output register.
// Reset clears every valid flag and loads the typical ratio defaults.
// When the receiver stalls, the output register holds its word; the rows
// keep moving while the last divider cell is empty, and otherwise the whole
// pipeline freezes and in_stall_o is raised.
// ----------------------------------------------------------------------------
module awb_gain_from_otp_ratios
  import awbg_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [RatioW-1:0]   cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [RatioW-1:0]   red_ratio_i,
  input  logic [RatioW-1:0]   blue_ratio_i,
  input  logic [RatioW-1:0]   light_red_factor_i,
  input  logic [RatioW-1:0]   light_blue_factor_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [GainW-1:0]    red_gain_o,
  output logic [GainW-1:0]    green_gain_o,
  output logic [GainW-1:0]    blue_gain_o,
  output logic [StatW-1:0]    status_o
);

  localparam int unsigned Side1W = 2 * SratioW;
  localparam int unsigned Side2W = Div1N + $bits(sel_ctl_t);

  logic [RatioW-1:0] typ_red_q, typ_blue_q;
  logic              adv, accept;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      typ_red_q  <= TypRedRst;
      typ_blue_q <= TypBlueRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TYP_RED:  typ_red_q  <= cfg_data_i;
        REG_TYP_BLUE: typ_blue_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Light scaling stage.
  logic [Div1N-1:0]   prod_r, prod_b;
  logic [SratioW-1:0] rg_d, bg_d, rg_q, bg_q;
  logic               s0_vld_q;

  always_comb begin
    prod_r = Div1N'(red_ratio_i)  * Div1N'({1'b0, light_red_factor_i} + LightBias);
    prod_b = Div1N'(blue_ratio_i) * Div1N'({1'b0, light_blue_factor_i} + LightBias);
    rg_d = (light_red_factor_i == '0)  ? {1'b0, red_ratio_i}  : prod_r[Div1N-1:10];
    bg_d = (light_blue_factor_i == '0) ? {1'b0, blue_ratio_i} : prod_b[Div1N-1:10];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (adv) begin
      s0_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rg_q <= rg_d;
      bg_q <= bg_d;
    end
  end

  // First divider row: lane a gives 1024*bg/tb, lane b gives 1024*rg/tr.
  logic              d1_vld;
  logic [Div1N-1:0]  gb, gr;
  logic [Side1W-1:0] d1_side;
  logic [SratioW-1:0] rg1, bg1;

  awbg_div_chain #(.N(Div1N), .M(RatioW), .SW(Side1W)) u_div1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .vld_i   (s0_vld_q),
    .dnd_a_i ({bg_q, 10'b0}),
    .dvs_a_i (typ_blue_q),
    .dnd_b_i ({rg_q, 10'b0}),
    .dvs_b_i (typ_red_q),
    .side_i  ({rg_q, bg_q}),
    .vld_o   (d1_vld),
    .quo_a_o (gb),
    .quo_b_o (gr),
    .side_o  (d1_side)
  );

  assign {rg1, bg1} = d1_side;

  // Case select stage.
  sel_ctl_t           ctl_d, ctl_q;
  logic [Div1N-1:0]   mr_d, mb_d, g_d, mr_q, mb_q, g_q;
  logic [SratioW-1:0] rg2_q, bg2_q;
  logic               sel_vld_q;
  logic               blt, rlt;

  always_comb begin
    blt        = bg1 < {1'b0, typ_blue_q};
    rlt        = rg1 < {1'b0, typ_red_q};
    ctl_d.zero = 1'b0;
    ctl_d.mode = MODE_G_UNITY;
    mr_d       = UnityGain;
    mb_d       = UnityGain;
    g_d        = UnityGain;
    if (blt && rlt) begin
      ctl_d.zero = (bg1 == '0) || (rg1 == '0);
    end else if (blt) begin
      ctl_d.zero = (typ_red_q == '0) || (bg1 == '0);
      ctl_d.mode = MODE_R_UNITY;
      g_d        = gr;
      mb_d       = gr;
    end else if (rlt) begin
      ctl_d.zero = (typ_blue_q == '0) || (rg1 == '0);
      ctl_d.mode = MODE_B_UNITY;
      g_d        = gb;
      mr_d       = gb;
    end else if (gb > gr) begin
      ctl_d.zero = (typ_blue_q == '0) || (typ_red_q == '0) || (rg1 == '0);
      ctl_d.mode = MODE_B_UNITY;
      g_d        = gb;
      mr_d       = gb;
    end else begin
      ctl_d.zero = (typ_blue_q == '0) || (typ_red_q == '0) || (bg1 == '0);
      ctl_d.mode = MODE_R_UNITY;
      g_d        = gr;
      mb_d       = gr;
    end
  end

  // Multiply stage builds the second-row dividends.
  sel_ctl_t           ctl_m_q;
  logic [Div2N-1:0]   dnd_r_q, dnd_b_q;
  logic [Div1N-1:0]   g_m_q;
  logic [SratioW-1:0] rg3_q, bg3_q;
  logic               mul_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_vld_q <= 1'b0;
      mul_vld_q <= 1'b0;
    end else if (adv) begin
      sel_vld_q <= d1_vld;
      mul_vld_q <= sel_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ctl_q   <= ctl_d;
      mr_q    <= mr_d;
      mb_q    <= mb_d;
      g_q     <= g_d;
      rg2_q   <= rg1;
      bg2_q   <= bg1;
      ctl_m_q <= ctl_q;
      dnd_r_q <= Div2N'(mr_q) * Div2N'(typ_red_q);
      dnd_b_q <= Div2N'(mb_q) * Div2N'(typ_blue_q);
      g_m_q   <= g_q;
      rg3_q   <= rg2_q;
      bg3_q   <= bg2_q;
    end
  end

  // Second divider row: lane a gives the red gain, lane b the blue gain.
  logic              d2_vld;
  logic [Div2N-1:0]  qr, qb;
  logic [Side2W-1:0] d2_side;
  logic [Div1N-1:0]  g_f;
  sel_ctl_t          ctl_f;

  awbg_div_chain #(.N(Div2N), .M(SratioW), .SW(Side2W)) u_div2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .vld_i   (mul_vld_q),
    .dnd_a_i (dnd_r_q),
    .dvs_a_i (rg3_q),
    .dnd_b_i (dnd_b_q),
    .dvs_b_i (bg3_q),
    .side_i  ({g_m_q, ctl_m_q}),
    .vld_o   (d2_vld),
    .quo_a_o (qr),
    .quo_b_o (qb),
    .side_o  (d2_side)
  );

  assign {g_f, ctl_f} = d2_side;

  // Clamp and output register.
  logic [GainW-1:0] r_d, g_o_d, b_d, r_q, g_o_q, b_q;
  stat_e            st_d, st_q;
  logic             sat_r, sat_g, sat_b;
  logic             out_vld_q, out_load;

  always_comb begin
    sat_r = (ctl_f.mode != MODE_R_UNITY) && (qr[Div2N-1:GainW] != '0);
    sat_b = (ctl_f.mode != MODE_B_UNITY) && (qb[Div2N-1:GainW] != '0);
    sat_g = (ctl_f.mode != MODE_G_UNITY) && (g_f[Div1N-1:GainW] != '0);
    r_d   = (ctl_f.mode == MODE_R_UNITY) ? GainUnity : (sat_r ? GainMax : qr[GainW-1:0]);
    b_d   = (ctl_f.mode == MODE_B_UNITY) ? GainUnity : (sat_b ? GainMax : qb[GainW-1:0]);
    g_o_d = (ctl_f.mode == MODE_G_UNITY) ? GainUnity : (sat_g ? GainMax : g_f[GainW-1:0]);
    st_d  = (sat_r || sat_g || sat_b) ? STAT_SAT : STAT_OK;
    if (ctl_f.zero) begin
      r_d   = GainMax;
      g_o_d = GainMax;
      b_d   = GainMax;
      st_d  = STAT_ZERO;
    end
  end

  assign out_load   = !out_vld_q || !out_stall_i;
  // The rows may shift while a word waits, as long as the last cell is empty.
  assign adv        = out_load || !d2_vld;
  assign accept     = in_valid_i && adv;
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= d2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      r_q   <= r_d;
      g_o_q <= g_o_d;
      b_q   <= b_d;
      st_q  <= st_d;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign red_gain_o   = r_q;
  assign green_gain_o = g_o_q;
  assign blue_gain_o  = b_q;
  assign status_o     = st_q;

  // A zero divisor word always carries saturated gains.
  a_zero_gains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (st_q == STAT_ZERO) |->
      (r_q == GainMax) && (g_o_q == GainMax) && (b_q == GainMax))
    else $error("zero divisor word without saturated gains");

  // Without a zero divisor one channel always sits at unity.
  a_unity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (st_q != STAT_ZERO) |->
      (r_q == GainUnity) || (g_o_q == GainUnity) || (b_q == GainUnity))
    else $error("no channel at unity gain");

  // An empty output register never stalls the input.
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q |-> !in_stall_o)
    else $error("input stalled with empty output register");

  // A held word must not be overwritten by the last divider cell.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_stall_i && d2_vld |=> out_vld_q && $stable(st_q) && $stable(r_q))
    else $error("held output word changed");

endmodule

FILE: test/tb_awb_gain_from_otp_ratios.sv
// ----------------------------------------------------------------------------
// tb_awb_gain_from_otp_ratios
// Drives ratio words with random gaps and receiver stalls, predicts or looks up
// three gains and the status of every word, and checks each result word in order.
// ----------------------------------------------------------------------------
module tb_awb_gain_from_otp_ratios;
  import awbg_pkg::*;

  localparam int NumRandom   = 1528;
  localparam int PhaseWords  = (NumRandom - 250) / 3;
  localparam int WatchLimit  = 4000;
  localparam int PipeLatency = 60;
  localparam int NumDirected = 22;

  typedef struct packed {
    logic [GainW-1:0] red;
    logic [GainW-1:0] green;
    logic [GainW-1:0] blue;
    stat_e            status;
  } gains_t;

  typedef struct packed {
    logic [RatioW-1:0] red;
    logic [RatioW-1:0] blue;
    logic [RatioW-1:0] light_red;
    logic [RatioW-1:0] light_blue;
  } ratios_t;

  typedef struct {
    ratios_t ratios;
    logic    known;
    gains_t  gains;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  cfg_reg_e cfg_idx_i = REG_TYP_RED;
  logic [RatioW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [RatioW-1:0] red_ratio_i = '0;
  logic [RatioW-1:0] blue_ratio_i = '0;
  logic [RatioW-1:0] light_red_factor_i = '0;
  logic [RatioW-1:0] light_blue_factor_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [GainW-1:0] red_gain_o, green_gain_o, blue_gain_o;
  logic [StatW-1:0] status_o;

  logic [RatioW-1:0] typ_red = TypRedRst;
  logic [RatioW-1:0] typ_blue = TypBlueRst;
  gains_t pending_gains[$];
  int errors = 0;
  int words_out = 0;
  int saturated = 0;
  int zero_div = 0;
  int idle_cycles = 0;
  bit long_hold = 1'b0;
  bit stim_done = 1'b0;
  row_t directed[NumDirected];

  always #5 clk_i = ~clk_i;

  awb_gain_from_otp_ratios dut (.*);

  function automatic logic [63:0] scale_ratio(logic [63:0] ratio, logic [63:0] light);
    if (light == 0) return ratio;
    return ratio * (light + 512) / 1024;
  endfunction

  function automatic logic [GainW-1:0] clip_gain(logic [63:0] g, ref bit sat);
    if (g > 65535) begin
      sat = 1'b1;
      return GainMax;
    end
    return g[GainW-1:0];
  endfunction

  function automatic gains_t predict_gains(ratios_t w, logic [63:0] tr, logic [63:0] tb);
    logic [63:0] rg, bg, r, g, b, gb, gr;
    bit zero, sat;
    gains_t res;
    rg = scale_ratio(64'(w.red), 64'(w.light_red));
    bg = scale_ratio(64'(w.blue), 64'(w.light_blue));
    r = 0; g = 0; b = 0; zero = 0; sat = 0;
    if (bg < tb && rg < tr) begin
      if (bg == 0 || rg == 0) zero = 1;
      else begin
        g = 1024; b = 1024 * tb / bg; r = 1024 * tr / rg;
      end
    end else if (bg < tb) begin
      if (tr == 0 || bg == 0) zero = 1;
      else begin
        r = 1024; g = 1024 * rg / tr; b = g * tb / bg;
      end
    end else if (rg < tr) begin
      if (tb == 0 || rg == 0) zero = 1;
      else begin
        b = 1024; g = 1024 * bg / tb; r = g * tr / rg;
      end
    end else if (tb == 0 || tr == 0) begin
      zero = 1;
    end else begin
      gb = 1024 * bg / tb;
      gr = 1024 * rg / tr;
      if (gb > gr) begin
        if (rg == 0) zero = 1;
        else begin
          b = 1024; g = gb; r = g * tr / rg;
        end
      end else begin
        if (bg == 0) zero = 1;
        else begin
          r = 1024; g = gr; b = g * tb / bg;
        end
      end
    end
    if (zero) begin
      res = '{GainMax, GainMax, GainMax, STAT_ZERO};
    end else begin
      res.red = clip_gain(r, sat);
      res.green = clip_gain(g, sat);
      res.blue = clip_gain(b, sat);
      res.status = sat ? STAT_SAT : STAT_OK;
    end
    return res;
  endfunction

  task automatic write_typical(cfg_reg_e idx, logic [RatioW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_TYP_RED) typ_red = val;
    else typ_blue = val;
    @(posedge clk_i);
  endtask

  // Waits until every result word has come back, then lets the pipe drain.
  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_gains.size() != 0) @(posedge clk_i);
    repeat (PipeLatency) @(posedge clk_i);
  endtask

  task automatic send_word(ratios_t w, logic known, gains_t exp_gains);
    int gap;
    gap = $urandom_range(0, 13);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    {red_ratio_i, blue_ratio_i, light_red_factor_i, light_blue_factor_i} <= w;
    pending_gains.push_back(known ? exp_gains :
                            predict_gains(w, 64'(typ_red), 64'(typ_blue)));
    do @(posedge clk_i); while (in_stall_o);
  endtask

  function automatic ratios_t random_word();
    logic [63:0] rnd;
    ratios_t w;
    rnd = {$urandom, $urandom};
    w = rnd[$bits(ratios_t)-1:0];
    case ($urandom_range(0, 5))
      0: w.light_red = '0;
      1: w.light_blue = '0;
      2: w.red = RatioW'($urandom_range(0, 3));
      3: w.blue = RatioW'($urandom_range(0, 3));
      default: ;
    endcase
    return w;
  endfunction

  // Receiver stalls; one long hold-off fills the pipe and stalls the input.
  initial begin
    int hold;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (!long_hold && words_out >= 600) begin
        long_hold = 1'b1;
        out_stall_i <= 1'b1;
        repeat (300) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (out_valid_o && !out_stall_i) begin
        hold = (words_out % 200 < 100) ? 0 : $urandom_range(0, 13);
        out_stall_i <= hold != 0;
        repeat (hold) @(posedge clk_i);
        if (hold != 0) out_stall_i <= 1'b0;
      end
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    gains_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {red_gain_o, green_gain_o, blue_gain_o, stat_e'(status_o)};
      words_out++;
      if (pending_gains.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word %h", $time, got);
      end else begin
        want = pending_gains.pop_front();
        if (got != want) begin
          errors++;
          $display("%0t: mismatch expected r=%0d g=%0d b=%0d s=%0d actual r=%0d g=%0d b=%0d s=%0d",
                   $time, want.red, want.green, want.blue, want.status,
                   got.red, got.green, got.blue, got.status);
        end
        if (want.status == STAT_SAT) saturated++;
        if (want.status == STAT_ZERO) zero_div++;
      end
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit && !stim_done) begin
      $display("tb_awb_gain_from_otp_ratios NOT OK");
      $finish;
    end
  end

  initial begin
    gains_t sat_all;
    sat_all = '{GainMax, GainMax, GainMax, STAT_ZERO};
    // Extremes, zero divisors and the light scaling; unity rows read off directly.
    directed[0]  = '{'{10'h127, 10'h14E, '0, '0}, 1'b1,
                     '{GainUnity, GainUnity, GainUnity, STAT_OK}};
    directed[1]  = '{'{'0, '0, '0, '0}, 1'b1, sat_all};
    directed[2]  = '{'{'0, 10'd5, '0, '0}, 1'b1, sat_all};
    directed[3]  = '{'{10'd5, '0, '0, '0}, 1'b1, sat_all};
    directed[4]  = '{'{10'h3FF, '0, '0, '0}, 1'b1, sat_all};
    directed[5]  = '{'{'0, 10'h3FF, '0, '0}, 1'b1, sat_all};
    directed[6]  = '{'{10'd1, 10'd1, '0, '0}, 1'b0, '0};
    directed[7]  = '{'{10'd1, 10'h3FF, '0, '0}, 1'b0, '0};
    directed[8]  = '{'{10'h3FF, 10'd1, '0, '0}, 1'b0, '0};
    directed[9]  = '{'{10'h3FF, 10'h3FF, '0, '0}, 1'b0, '0};
    directed[10] = '{'{10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF}, 1'b0, '0};
    directed[11] = '{'{10'd1, 10'd1, 10'h3FF, 10'h3FF}, 1'b0, '0};
    directed[12] = '{'{10'd1, 10'd1, 10'd1, 10'd1}, 1'b1, sat_all};
    directed[13] = '{'{10'h127, 10'h14E, 10'd512, 10'd512}, 1'b1,
                     '{GainUnity, GainUnity, GainUnity, STAT_OK}};
    directed[14] = '{'{10'h200, 10'h100, 10'd1, 10'd1}, 1'b0, '0};
    directed[15] = '{'{10'h100, 10'h200, '0, '0}, 1'b0, '0};
    directed[16] = '{'{10'h200, 10'h200, '0, '0}, 1'b0, '0};
    directed[17] = '{'{10'h100, 10'h100, '0, '0}, 1'b0, '0};
    directed[18] = '{'{10'h155, 10'h2AA, 10'h2AA, 10'h155}, 1'b0, '0};
    directed[19] = '{'{10'h2AA, 10'h155, 10'h155, 10'h2AA}, 1'b0, '0};
    directed[20] = '{'{10'h128, 10'h14D, '0, '0}, 1'b0, '0};
    directed[21] = '{'{10'h126, 10'h14F, '0, '0}, 1'b0, '0};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) send_word(directed[i].ratios, directed[i].known, directed[i].gains);
    drain();
    // Typical ratios at the extremes, including zero, then random settings.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin write_typical(REG_TYP_RED, 10'd1); write_typical(REG_TYP_BLUE, 10'h3FF); end
        1: begin write_typical(REG_TYP_RED, 10'h3FF); write_typical(REG_TYP_BLUE, 10'd1); end
        2: begin write_typical(REG_TYP_RED, 10'd0); write_typical(REG_TYP_BLUE, 10'd0); end
        3: begin write_typical(REG_TYP_RED, TypRedRst); write_typical(REG_TYP_BLUE, 10'd0); end
        4: begin write_typical(REG_TYP_RED, 10'd0); write_typical(REG_TYP_BLUE, TypBlueRst); end
        default: begin
          write_typical(REG_TYP_RED, RatioW'($urandom_range(1, 1023)));
          write_typical(REG_TYP_BLUE, RatioW'($urandom_range(1, 1023)));
        end
      endcase
      for (int n = 0; n < (phase < 5 ? 50 : PhaseWords); n++) send_word(random_word(), 1'b0, '0);
      drain();
    end
    stim_done = 1'b1;
    $display("Covered %0d result words, %0d saturated and %0d with a zero divisor,",
             words_out, saturated, zero_div);
    $display("across eight typical ratio settings with random gaps and stalls.");
    if (errors == 0) $display("tb_awb_gain_from_otp_ratios OK");
    else $display("tb_awb_gain_from_otp_ratios NOT OK");
    $finish;
  end

endmodule
